[design/lhs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link handshake package
// Shared widths, configuration register indexes and reset values for the
// link handshake state machine.
// ----------------------------------------------------------------------------
package lhs_pkg;

    localparam int ID_W       = 64;
    localparam int WAIT_W     = 16;
    localparam int COUNT_W    = 17;
    localparam int STATE_W    = 4;
    localparam int RAND_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 80;
    localparam int IN_USED_W  = 78;
    localparam int OUT_DATA_W = 16;
    localparam int ID_BYTES_DEFAULT = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_OUR_ID          = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAIT_HALF       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAIT_FULL       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAIT_LONG       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_WAIT_RESET_BASE = 3'd4;

    localparam logic [WAIT_W-1:0] WAIT_HALF_RST       = 16'd50;
    localparam logic [WAIT_W-1:0] WAIT_FULL_RST       = 16'd100;
    localparam logic [WAIT_W-1:0] WAIT_LONG_RST       = 16'd1000;
    localparam logic [WAIT_W-1:0] WAIT_RESET_BASE_RST = 16'd10;

    localparam logic [STATE_W-1:0] STATE_COUNT = 4'd11;

endpackage

[design/link_handshake_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Link handshake state machine
// One side of the link-training handshake between neighbour tiles.
// ----------------------------------------------------------------------------
// Usage:
// Input words arrive on s_axis; tuser selects a tick (0) or a received packet
// (1), and tdata carries the enable, coin, random wait, peer state and peer id.
// Every input word produces exactly one output word on m_axis, giving the
// packet to send (if any) and the handshake state after the word.
// A word is taken into an input register, processed in one pass of
// combinational logic and written to the output register once the output
// register is empty or its word is taken by the receiver.
// One word per cycle is accepted for as long as the output side keeps up;
// the rate is set by the single state and countdown update per cycle.
// When the receiver stalls, the result waits in the output register and the
// next word waits in the input register; further input is then held off.
// The cfg port writes registers by index (0 our id, 1 half wait, 2 full wait,
// 3 long wait, 4 reset base wait); it is to be used only while the block is
// idle, which the block itself does not enforce. Reset puts the machine
// in INIT with a countdown of ten ticks and registers at default values.
// ----------------------------------------------------------------------------
module link_handshake_fsm
    import lhs_pkg::*;
#(
    parameter int ID_BYTES = ID_BYTES_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ID_W-1:0]       cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: link_enabled, coin, random_wait[7:0], peer_state[3:0],
    // peer_id[63:0], zero padding.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: op.
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: send_valid, send_state[3:0], send_has_id,
    // link_state[3:0], zero padding.
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int ID_BITS = 8 * ID_BYTES;
    localparam logic [ID_W-1:0] ID_MASK = {ID_W{1'b1}} >> (ID_W - ID_BITS);

    typedef enum logic [STATE_W-1:0] {
        ST_INIT         = 4'd0,
        ST_WAITPS       = 4'd1,
        ST_LEAD         = 4'd2,
        ST_WLEAD        = 4'd3,
        ST_FOLLOW       = 4'd4,
        ST_WFOLLOW      = 4'd5,
        ST_CONFIG       = 4'd6,
        ST_WCONFIG      = 4'd7,
        ST_CHECK        = 4'd8,
        ST_COMPATIBLE   = 4'd9,
        ST_INCOMPATIBLE = 4'd10
    } hs_state_t;

    logic [ID_W-1:0]      our_id_reg;
    logic [WAIT_W-1:0]    wait_half_reg;
    logic [WAIT_W-1:0]    wait_full_reg;
    logic [WAIT_W-1:0]    wait_long_reg;
    logic [WAIT_W-1:0]    wait_reset_base_reg;

    logic                 in_valid_reg;
    logic                 op_reg;
    logic [IN_USED_W-1:0] in_data_reg;

    hs_state_t            state_reg;
    hs_state_t            state_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [COUNT_W-1:0]   count_next;
    logic [ID_W-1:0]      peer_id_reg;
    logic [ID_W-1:0]      peer_id_next;

    logic                 out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;

    logic                 advance;
    logic                 link_enabled;
    logic                 coin;
    logic [RAND_W-1:0]    random_wait;
    logic [STATE_W-1:0]   peer_state;
    logic [ID_W-1:0]      peer_id;
    logic [COUNT_W-1:0]   reset_wait;
    logic                 store_match;
    logic                 packet_match;
    logic                 send_valid;
    logic [STATE_W-1:0]   send_state;
    logic                 send_has_id;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign link_enabled = in_data_reg[0];
    assign coin         = in_data_reg[1];
    assign random_wait  = in_data_reg[9:2];
    assign peer_state   = in_data_reg[13:10];
    assign peer_id      = in_data_reg[77:14] & ID_MASK;

    assign reset_wait   = {1'b0, wait_reset_base_reg} + {{(COUNT_W-RAND_W){1'b0}}, random_wait};
    assign store_match  = (our_id_reg & ID_MASK) == (peer_id_reg & ID_MASK);
    assign packet_match = (our_id_reg & ID_MASK) == peer_id;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        peer_id_next = peer_id_reg;
        send_valid   = 1'b0;
        send_state   = '0;
        send_has_id  = 1'b0;
        if (!op_reg)
        begin
            if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
            else
            begin
                case (state_reg)
                    ST_WAITPS:
                    begin
                        if (link_enabled)
                        begin
                            state_next = ST_LEAD;
                        end
                        else
                        begin
                            count_next = {1'b0, wait_long_reg};
                        end
                    end
                    ST_LEAD, ST_FOLLOW, ST_CONFIG:
                    begin
                        state_next  = hs_state_t'(state_reg + 1'b1);
                        count_next  = {1'b0, wait_full_reg};
                        send_valid  = 1'b1;
                        send_state  = state_reg;
                        send_has_id = (state_reg == ST_CONFIG);
                    end
                    ST_CHECK:
                    begin
                        state_next  = store_match ? ST_COMPATIBLE : ST_INCOMPATIBLE;
                        count_next  = {1'b0, wait_full_reg};
                        send_valid  = 1'b1;
                        send_state  = state_reg;
                        send_has_id = 1'b1;
                    end
                    ST_COMPATIBLE, ST_INCOMPATIBLE:
                    begin
                        count_next = {1'b0, wait_long_reg};
                        send_valid = 1'b1;
                        send_state = state_reg;
                    end
                    default:
                    begin
                        state_next = ST_WAITPS;
                        count_next = reset_wait;
                    end
                endcase
            end
        end
        else if (peer_state < STATE_COUNT)
        begin
            case (peer_state)
                ST_LEAD:
                begin
                    if (state_reg == ST_WLEAD && coin)
                    begin
                        state_next = ST_WAITPS;
                        count_next = reset_wait;
                    end
                    else
                    begin
                        state_next = ST_FOLLOW;
                        count_next = {1'b0, wait_half_reg};
                    end
                end
                ST_FOLLOW:
                begin
                    if (state_reg == ST_WLEAD)
                    begin
                        state_next = ST_CONFIG;
                        count_next = {1'b0, wait_half_reg};
                    end
                    else
                    begin
                        state_next = ST_WAITPS;
                        count_next = reset_wait;
                    end
                end
                ST_CONFIG:
                begin
                    if (state_reg == ST_WFOLLOW)
                    begin
                        peer_id_next = peer_id;
                        state_next   = ST_CHECK;
                        count_next   = {1'b0, wait_half_reg};
                    end
                    else
                    begin
                        state_next = ST_WAITPS;
                        count_next = reset_wait;
                    end
                end
                ST_CHECK:
                begin
                    if (state_reg == ST_WCONFIG)
                    begin
                        peer_id_next = peer_id;
                        state_next   = packet_match ? ST_COMPATIBLE : ST_INCOMPATIBLE;
                        count_next   = {1'b0, wait_half_reg};
                    end
                    else
                    begin
                        state_next = ST_WAITPS;
                        count_next = reset_wait;
                    end
                end
                ST_COMPATIBLE, ST_INCOMPATIBLE:
                begin
                    if (state_reg != peer_state)
                    begin
                        state_next = ST_WAITPS;
                    end
                    count_next = {1'b0, wait_long_reg};
                end
                default:
                begin
                    state_next = ST_WAITPS;
                    count_next = reset_wait;
                end
            endcase
        end
        out_data_next = {6'd0, state_next, send_has_id, send_state, send_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            our_id_reg          <= '0;
            wait_half_reg       <= WAIT_HALF_RST;
            wait_full_reg       <= WAIT_FULL_RST;
            wait_long_reg       <= WAIT_LONG_RST;
            wait_reset_base_reg <= WAIT_RESET_BASE_RST;
            in_valid_reg        <= 1'b0;
            op_reg              <= 1'b0;
            in_data_reg         <= '0;
            state_reg           <= ST_INIT;
            count_reg           <= {1'b0, WAIT_RESET_BASE_RST};
            peer_id_reg         <= '0;
            out_valid_reg       <= 1'b0;
            out_data_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    CFG_OUR_ID:          our_id_reg          <= cfg_wdata;
                    CFG_WAIT_HALF:       wait_half_reg       <= cfg_wdata[WAIT_W-1:0];
                    CFG_WAIT_FULL:       wait_full_reg       <= cfg_wdata[WAIT_W-1:0];
                    CFG_WAIT_LONG:       wait_long_reg       <= cfg_wdata[WAIT_W-1:0];
                    CFG_WAIT_RESET_BASE: wait_reset_base_reg <= cfg_wdata[WAIT_W-1:0];
                    default:             ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
                op_reg       <= s_axis_tuser;
                in_data_reg  <= s_axis_tdata[IN_USED_W-1:0];
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                state_reg     <= state_next;
                count_reg     <= count_next;
                peer_id_reg   <= peer_id_next;
                out_valid_reg <= 1'b1;
                out_data_reg  <= out_data_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule
